FILE: design/ubdc_pkg.sv
// Shared types, constants and helper functions for the UART baud divisor calculator.
// Used by the controller, the datapath and the top level; depends on nothing else.
package ubdc_pkg;

  localparam int unsigned ClkW   = 28;
  localparam int unsigned BaudW  = 22;
  localparam int unsigned CntW   = 5;
  localparam int unsigned BrdW   = 16;
  localparam int unsigned StW    = 2;
  localparam int unsigned DxW    = 4;

  localparam logic [CntW-1:0]  CntLast  = CntW'(ClkW - 1);
  localparam logic [BrdW-1:0]  BrdMax   = 16'hFFFF;
  localparam logic [ClkW-1:0]  QuoOver  = 28'h001_0001;
  localparam logic [DxW-1:0]   DxFirst  = 4'd8;
  localparam logic [DxW-1:0]   DxLast   = 4'd15;

  localparam logic [StW-1:0] StOk    = 2'd0;
  localparam logic [StW-1:0] StFast  = 2'd1;
  localparam logic [StW-1:0] StRange = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_EVAL,
    S_SDIV,
    S_SEVAL,
    S_FINISH
  } state_e;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_DIV16,
    RES_DIV1,
    RES_FOUND,
    RES_FAIL
  } res_e;

  typedef struct packed {
    logic load_in;
    logic step;
    logic search_init;
    logic search_next;
    logic res_we;
    res_e res_sel;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic baud_zero;
    logic cnt_last;
    logic mod16_lt2;
    logic q_over;
    logic rem_lt3;
    logic d_last;
  } ctrl_sts_t;

  typedef struct packed {
    logic [BrdW-1:0] brd;
    logic [StW-1:0]  status;
  } brd_res_t;

  function automatic brd_res_t make_brd(input logic [ClkW-1:0] quo);
    brd_res_t r;
    logic [ClkW-1:0] m2;
    m2 = quo - ClkW'(2);
    if (quo < ClkW'(2)) begin
      r.brd    = '0;
      r.status = StFast;
    end else if (quo > QuoOver) begin
      r.brd    = BrdMax;
      r.status = StRange;
    end else begin
      r.brd    = m2[BrdW-1:0];
      r.status = StOk;
    end
    return r;
  endfunction

endpackage

FILE: design/ubdc_datapath.sv
// Datapath of the UART baud divisor calculator: serial restoring divider,
// divider X search registers and result registers. Depends on ubdc_pkg.
module ubdc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ubdc_pkg::ClkW-1:0]     src_clk_i,
  input  logic [ubdc_pkg::BaudW-1:0]    baud_i,
  input  ubdc_pkg::ctrl_cmd_t           cmd_i,
  output ubdc_pkg::ctrl_sts_t           sts_o,
  output logic                          x_en_o,
  output logic                          x_one_o,
  output logic [ubdc_pkg::DxW-1:0]      x_div_o,
  output logic [ubdc_pkg::BrdW-1:0]     brd_o,
  output logic [ubdc_pkg::StW-1:0]      status_o
);

  logic [ubdc_pkg::BaudW-1:0] baud_q;
  logic [ubdc_pkg::BaudW-1:0] div_q, div_d;
  logic [ubdc_pkg::BaudW-1:0] rem_q, rem_d;
  logic [ubdc_pkg::ClkW-1:0]  quo_q, quo_d;
  logic [ubdc_pkg::ClkW-1:0]  qsave_q;
  logic [ubdc_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [ubdc_pkg::DxW-1:0]   dx_q, dx_d;
  logic [ubdc_pkg::BaudW:0]   partial;
  logic [ubdc_pkg::BaudW:0]   diff;
  logic                       ge;
  logic [ubdc_pkg::DxW:0]     dx_plus;

  logic                        res_en_q, res_one_q;
  logic [ubdc_pkg::DxW-1:0]    res_dx_q;
  logic [ubdc_pkg::BrdW-1:0]   res_brd_q;
  logic [ubdc_pkg::StW-1:0]    res_st_q;
  ubdc_pkg::brd_res_t          mb16, mb1, mbq;

  assign partial = {rem_q, quo_q[ubdc_pkg::ClkW-1]};
  assign diff    = partial - {1'b0, div_q};
  assign ge      = partial >= {1'b0, div_q};
  assign dx_plus = {1'b0, dx_q} + (ubdc_pkg::DxW+1)'(2);

  always_comb begin
    div_d = div_q;
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    dx_d  = dx_q;
    if (cmd_i.load_in) begin
      div_d = baud_i;
      rem_d = '0;
      quo_d = src_clk_i;
      cnt_d = '0;
    end else if (cmd_i.search_init) begin
      div_d = ubdc_pkg::BaudW'({1'b0, ubdc_pkg::DxFirst} + (ubdc_pkg::DxW+1)'(1));
      rem_d = '0;
      quo_d = quo_q;
      cnt_d = '0;
      dx_d  = ubdc_pkg::DxFirst;
    end else if (cmd_i.search_next) begin
      div_d = ubdc_pkg::BaudW'(dx_plus);
      rem_d = '0;
      quo_d = qsave_q;
      cnt_d = '0;
      dx_d  = dx_q + ubdc_pkg::DxW'(1);
    end else if (cmd_i.step) begin
      rem_d = ge ? diff[ubdc_pkg::BaudW-1:0] : partial[ubdc_pkg::BaudW-1:0];
      quo_d = {quo_q[ubdc_pkg::ClkW-2:0], ge};
      cnt_d = cnt_q + ubdc_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dx_q  <= dx_d;
    if (cmd_i.load_in) begin
      baud_q <= baud_i;
    end
    if (cmd_i.search_init) begin
      qsave_q <= quo_q;
    end
  end

  assign mb16 = ubdc_pkg::make_brd({4'd0, quo_q[ubdc_pkg::ClkW-1:4]});
  assign mb1  = ubdc_pkg::make_brd(quo_q);
  assign mbq  = mb1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_we) begin
      unique case (cmd_i.res_sel)
        ubdc_pkg::RES_ZERO: begin
          res_en_q  <= 1'b0;
          res_one_q <= 1'b0;
          res_dx_q  <= '0;
          res_brd_q <= ubdc_pkg::BrdMax;
          res_st_q  <= ubdc_pkg::StRange;
        end
        ubdc_pkg::RES_DIV16: begin
          res_en_q  <= 1'b0;
          res_one_q <= 1'b0;
          res_dx_q  <= '0;
          res_brd_q <= mb16.brd;
          res_st_q  <= mb16.status;
        end
        ubdc_pkg::RES_DIV1: begin
          res_en_q  <= 1'b1;
          res_one_q <= 1'b1;
          res_dx_q  <= '0;
          res_brd_q <= mb1.brd;
          res_st_q  <= mb1.status;
        end
        ubdc_pkg::RES_FOUND: begin
          res_en_q  <= 1'b1;
          res_one_q <= 1'b0;
          res_dx_q  <= dx_q;
          res_brd_q <= mbq.brd;
          res_st_q  <= mbq.status;
        end
        default: begin
          res_en_q  <= 1'b1;
          res_one_q <= 1'b0;
          res_dx_q  <= '0;
          res_brd_q <= ubdc_pkg::BrdMax;
          res_st_q  <= ubdc_pkg::StRange;
        end
      endcase
    end
    if (cmd_i.out_load) begin
      x_en_o   <= res_en_q;
      x_one_o  <= res_one_q;
      x_div_o  <= res_dx_q;
      brd_o    <= res_brd_q;
      status_o <= res_st_q;
    end
  end

  assign sts_o.baud_zero = (baud_q == '0);
  assign sts_o.cnt_last  = (cnt_q == ubdc_pkg::CntLast);
  assign sts_o.mod16_lt2 = (quo_q[3:0] < 4'd2);
  assign sts_o.q_over    = (quo_q > ubdc_pkg::QuoOver);
  assign sts_o.rem_lt3   = (rem_q < ubdc_pkg::BaudW'(3));
  assign sts_o.d_last    = (dx_q == ubdc_pkg::DxLast);

`ifndef NO_ASSERTIONS
  a_search_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.search_init |=> (div_q == ubdc_pkg::BaudW'(9)) && (dx_q == ubdc_pkg::DxFirst))
    else $error("search did not start at divider X of eight");
  a_step_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && !cmd_i.load_in && !cmd_i.search_init && !cmd_i.search_next)
      |=> cnt_q == $past(cnt_q) + ubdc_pkg::CntW'(1))
    else $error("divider step count did not advance");
`endif

endmodule

FILE: design/ubdc_ctrl.sv
// Controller state machine of the UART baud divisor calculator.
// Sequences the datapath and owns both handshakes. Depends on ubdc_pkg.
module ubdc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  ubdc_pkg::ctrl_sts_t  sts_i,
  output ubdc_pkg::ctrl_cmd_t  cmd_o
);

  ubdc_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ubdc_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ubdc_pkg::S_IDLE:   if (in_valid_i) state_d = ubdc_pkg::S_DIV;
      ubdc_pkg::S_DIV:    if (sts_i.cnt_last) state_d = ubdc_pkg::S_EVAL;
      ubdc_pkg::S_EVAL: begin
        if (!sts_i.baud_zero && !sts_i.mod16_lt2 && sts_i.q_over) begin
          state_d = ubdc_pkg::S_SDIV;
        end else begin
          state_d = ubdc_pkg::S_FINISH;
        end
      end
      ubdc_pkg::S_SDIV:   if (sts_i.cnt_last) state_d = ubdc_pkg::S_SEVAL;
      ubdc_pkg::S_SEVAL: begin
        if (sts_i.rem_lt3 || sts_i.d_last) begin
          state_d = ubdc_pkg::S_FINISH;
        end else begin
          state_d = ubdc_pkg::S_SDIV;
        end
      end
      ubdc_pkg::S_FINISH: if (out_free) state_d = ubdc_pkg::S_IDLE;
      default:            state_d = ubdc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.res_sel = ubdc_pkg::RES_FAIL;
    unique case (state_q)
      ubdc_pkg::S_IDLE:   cmd_o.load_in = in_valid_i;
      ubdc_pkg::S_DIV:    cmd_o.step = 1'b1;
      ubdc_pkg::S_EVAL: begin
        if (sts_i.baud_zero) begin
          cmd_o.res_we  = 1'b1;
          cmd_o.res_sel = ubdc_pkg::RES_ZERO;
        end else if (sts_i.mod16_lt2) begin
          cmd_o.res_we  = 1'b1;
          cmd_o.res_sel = ubdc_pkg::RES_DIV16;
        end else if (sts_i.q_over) begin
          cmd_o.search_init = 1'b1;
        end else begin
          cmd_o.res_we  = 1'b1;
          cmd_o.res_sel = ubdc_pkg::RES_DIV1;
        end
      end
      ubdc_pkg::S_SDIV:   cmd_o.step = 1'b1;
      ubdc_pkg::S_SEVAL: begin
        if (sts_i.rem_lt3) begin
          cmd_o.res_we  = 1'b1;
          cmd_o.res_sel = ubdc_pkg::RES_FOUND;
        end else if (sts_i.d_last) begin
          cmd_o.res_we  = 1'b1;
          cmd_o.res_sel = ubdc_pkg::RES_FAIL;
        end else begin
          cmd_o.search_next = 1'b1;
        end
      end
      ubdc_pkg::S_FINISH: cmd_o.out_load = out_free;
      default:            cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ubdc_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ubdc_pkg::S_IDLE && in_valid_i) |=> state_q == ubdc_pkg::S_DIV)
    else $error("accepted request did not start the division");
  a_finish_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ubdc_pkg::S_FINISH && out_free) |=> out_valid_q && state_q == ubdc_pkg::S_IDLE)
    else $error("finished result was not presented");
  a_search_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ubdc_pkg::S_SEVAL && !sts_i.rem_lt3 && !sts_i.d_last)
      |=> state_q == ubdc_pkg::S_SDIV)
    else $error("divider X search stopped early");
`endif

endmodule

FILE: design/uart_baud_divisor_calc_top.sv
// Top level of the UART baud divisor calculator: APB register, stream ports,
// controller and datapath. Depends on ubdc_pkg, ubdc_ctrl and ubdc_datapath.
//
// A request on the slave stream carries a baud rate; the matching result on the
// master stream carries the divider X enable, divide-by-one select, divider X,
// BRD value and a status code. The source clock frequency is set through the
// APB register at address 0 (reset value 12000000); the user must write it only
// while no request is active; the block itself does not enforce this. A request
// is taken only when the block is idle. It runs one serial restoring division of
// clock by baud rate, then one evaluation step. When the divide-by-one BRD
// overflows, the divider X search runs up to eight more divisions. Requests are
// handled one at a time: the next one can be taken once the result has been
// loaded into the output register and the controller is back in idle. A finished
// result waits in the output register while a new request is already taken; if
// the receiver still stalls when the next result is done, the block holds it
// until the output register frees up.
// Reset drops m_axis_tvalid and returns the controller to idle.
module uart_baud_divisor_calc_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [21:0] baud_rate, [23:22] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [0] xdiv_enable, [1] xdiv_one,
                                      // [5:2] xdiv, [21:6] brd, [23:22] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  logic [ubdc_pkg::ClkW-1:0] src_clk_q;
  ubdc_pkg::ctrl_cmd_t       cmd;
  ubdc_pkg::ctrl_sts_t       sts;
  logic                      x_en, x_one;
  logic [ubdc_pkg::DxW-1:0]  x_div;
  logic [ubdc_pkg::BrdW-1:0] brd;
  logic [ubdc_pkg::StW-1:0]  status;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {4'd0, src_clk_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_clk_q <= 28'd12000000;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      src_clk_q <= pwdata[ubdc_pkg::ClkW-1:0];
    end
  end

  ubdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ubdc_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .src_clk_i (src_clk_q),
    .baud_i    (s_axis_tdata[ubdc_pkg::BaudW-1:0]),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .x_en_o    (x_en),
    .x_one_o   (x_one),
    .x_div_o   (x_div),
    .brd_o     (brd),
    .status_o  (status)
  );

  assign m_axis_tdata = {2'b00, brd, x_div, x_one, x_en};
  assign m_axis_tuser = status;

endmodule

FILE: tb/tb_uart_baud_divisor_calc_top.sv
// Self-checking testbench for the UART baud divisor calculator top level.
// Each baud rate request is predicted from the source clock register and
// checked against the result stream. Depends on ubdc_pkg and the RTL.
module tb_uart_baud_divisor_calc_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  ClkRegAddr   = 3'd0;
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned RxHoldCycles = 500;
  localparam int unsigned PhaseItems   = 165;
  localparam int unsigned NumClocks    = 9;

  typedef struct packed {
    logic                      x_en;
    logic                      x_one;
    logic [ubdc_pkg::DxW-1:0]  x_div;
    logic [ubdc_pkg::BrdW-1:0] brd;
    logic [ubdc_pkg::StW-1:0]  status;
  } divisor_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  logic [ubdc_pkg::BaudW-1:0] pending_baud [$];
  divisor_t                   divisor_q [$];
  logic [ubdc_pkg::ClkW-1:0]  clock_hz = ubdc_pkg::ClkW'(12000000);

  bit          offering    = 1'b0;
  bit          calm_tx     = 1'b0;
  bit          calm_rx     = 1'b0;
  bit          rx_hold_req = 1'b0;
  int unsigned rx_hold_left = 0;
  int unsigned stall_cycles = 0;
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned n_div16 = 0, n_div1 = 0, n_search = 0, n_fast = 0, n_range = 0;

  uart_baud_divisor_calc_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [ubdc_pkg::BrdW+ubdc_pkg::StW-1:0] brd_from_quotient(
      input logic [ubdc_pkg::ClkW-1:0] quo);
    if (quo < 2) return {ubdc_pkg::BrdW'(0), ubdc_pkg::StFast};
    if (32'(quo) - 32'd2 > 32'hFFFF) return {ubdc_pkg::BrdMax, ubdc_pkg::StRange};
    return {ubdc_pkg::BrdW'(quo - 2), ubdc_pkg::StOk};
  endfunction

  function automatic divisor_t divisor_for(input logic [ubdc_pkg::ClkW-1:0]  clk_hz,
                                           input logic [ubdc_pkg::BaudW-1:0] baud);
    divisor_t                  r;
    logic [ubdc_pkg::ClkW-1:0] q;
    int unsigned               d;
    bit                        hit;
    r   = '0;
    hit = 1'b0;
    if (baud == 0) begin
      r.brd    = ubdc_pkg::BrdMax;
      r.status = ubdc_pkg::StRange;
    end else begin
      q = clk_hz / baud;
      if (q % 16 < 2) begin
        {r.brd, r.status} = brd_from_quotient(ubdc_pkg::ClkW'(q / 16));
      end else begin
        r.x_en  = 1'b1;
        r.x_one = 1'b1;
        {r.brd, r.status} = brd_from_quotient(q);
        if (r.status == ubdc_pkg::StRange) begin
          r.x_one = 1'b0;
          for (d = ubdc_pkg::DxFirst; d <= ubdc_pkg::DxLast && !hit; d++) begin
            if (q % (d + 1) < 3) begin
              hit     = 1'b1;
              r.x_div = ubdc_pkg::DxW'(d);
              {r.brd, r.status} = brd_from_quotient(ubdc_pkg::ClkW'(q / (d + 1)));
            end
          end
          if (!hit) begin
            r.x_div  = '0;
            r.brd    = ubdc_pkg::BrdMax;
            r.status = ubdc_pkg::StRange;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic logic [ubdc_pkg::BaudW-1:0] pick_baud(
      input logic [ubdc_pkg::ClkW-1:0] clk_hz);
    int unsigned sel;
    logic [31:0] m;
    sel = $urandom_range(99);
    if (sel < 5) return '0;
    if (sel < 30) return ubdc_pkg::BaudW'($urandom_range(255, 1));
    if (sel < 50) return ubdc_pkg::BaudW'($urandom_range(65535, 256));
    if (sel < 70) return ubdc_pkg::BaudW'($urandom_range(4194303, 65536));
    if (sel < 80) return ubdc_pkg::BaudW'($urandom);
    m = $urandom_range(70000, 1) * 16 + $urandom_range(1, 0);
    if (clk_hz / m == 0) return ubdc_pkg::BaudW'($urandom_range(4, 1));
    return ubdc_pkg::BaudW'(clk_hz / m);
  endfunction

  task automatic write_clock(input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ClkRegAddr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    clock_hz = value[ubdc_pkg::ClkW-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic queue_random(input int unsigned n);
    repeat (n) pending_baud.push_back(pick_baud(clock_hz));
  endtask

  task automatic drain();
    while (pending_baud.size() != 0 || divisor_q.size() != 0 || offering) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (!offering) begin
      if (pending_baud.size() > 0 && (calm_tx || $urandom_range(99) >= 38)) begin
        s_axis_tdata  <= {2'b00, pending_baud[0]};
        s_axis_tvalid <= 1'b1;
        offering = 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_left = RxHoldCycles;
      rx_hold_req  = 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm_rx || ($urandom_range(99) >= 38);
    end
  end

  always @(posedge clk_i) begin : req_capture
    divisor_t want;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      want = divisor_for(clock_hz, s_axis_tdata[ubdc_pkg::BaudW-1:0]);
      divisor_q.push_back(want);
      if (!want.x_en) n_div16++;
      else if (want.x_one) n_div1++;
      else n_search++;
      if (want.status == ubdc_pkg::StFast) n_fast++;
      if (want.status == ubdc_pkg::StRange) n_range++;
      void'(pending_baud.pop_front());
      offering = 1'b0;
    end
  end

  always @(posedge clk_i) begin : res_check
    divisor_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (divisor_q.size() == 0) begin
        $error("result with no request outstanding: tdata %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = divisor_q.pop_front();
        results_seen++;
        if (m_axis_tdata[0] !== want.x_en) begin
          $error("xdiv_enable: expected %0d, got %0d", want.x_en, m_axis_tdata[0]);
          mismatches++;
        end
        if (m_axis_tdata[1] !== want.x_one) begin
          $error("xdiv_one: expected %0d, got %0d", want.x_one, m_axis_tdata[1]);
          mismatches++;
        end
        if (m_axis_tdata[5:2] !== want.x_div) begin
          $error("xdiv: expected %0d, got %0d", want.x_div, m_axis_tdata[5:2]);
          mismatches++;
        end
        if (m_axis_tdata[21:6] !== want.brd) begin
          $error("brd: expected %0d, got %0d", want.brd, m_axis_tdata[21:6]);
          mismatches++;
        end
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("Timeout after %0d cycles with no transfer", stall_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [31:0]                clocks [NumClocks];
    logic [ubdc_pkg::BaudW-1:0] directed [$];
    int unsigned                p;
    clocks[0] = 32'd1;
    clocks[1] = 32'd200000000;
    clocks[2] = 32'h0FFF_FFFF;
    clocks[3] = 32'd0;
    clocks[4] = $urandom_range(5000000, 1000);
    clocks[5] = $urandom_range(200000000, 1);
    clocks[6] = $urandom_range(200000000, 1);
    clocks[7] = {4'hA, 28'd12000000};
    clocks[8] = 32'd48000000;
    directed = '{0, 1, 2, 3, 7, 10, 11, 100, 110, 150, 300, 1200, 9600, 115200,
                 250000, 750000, 1000000, 2796202, 4000000, 4194303};

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) pending_baud.push_back(directed[i]);
    drain();

    for (p = 0; p < NumClocks; p++) begin
      write_clock(clocks[p]);
      calm_tx = (p == 1);
      calm_rx = (p == 1);
      if (p == 2) begin
        // Stall the result side while requests keep coming, then let it all settle.
        calm_tx     = 1'b1;
        rx_hold_req = 1'b1;
        queue_random(40);
        drain();
        calm_tx = 1'b0;
        queue_random(PhaseItems - 40);
      end else begin
        queue_random(PhaseItems);
      end
      drain();
    end

    calm_tx = 1'b0;
    calm_rx = 1'b0;
    repeat (40) @(posedge clk_i);

    $display("Checked %0d results over %0d clock settings plus the reset value.",
             results_seen, NumClocks);
    $display("Modes: %0d divide-by-16, %0d divide-by-one, %0d divider X;",
             n_div16, n_div1, n_search);
    $display("Status: %0d too fast, %0d out of range.", n_fast, n_range);
    if (mismatches == 0 && divisor_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/ubdc_pkg.sv
design/ubdc_datapath.sv
design/ubdc_ctrl.sv
design/uart_baud_divisor_calc_top.sv
tb/tb_uart_baud_divisor_calc_top.sv
